// ===== sv/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared types, phase codes and keyword tables of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

  localparam int unsigned MaxRequestBytes = 2048;
  localparam int unsigned CountW = $clog2(MaxRequestBytes + 1);

  localparam logic [3:0] PH_METHOD     = 4'd0;
  localparam logic [3:0] PH_URL_LEAD   = 4'd1;
  localparam logic [3:0] PH_URL        = 4'd2;
  localparam logic [3:0] PH_VER_LEAD   = 4'd3;
  localparam logic [3:0] PH_VERSION    = 4'd4;
  localparam logic [3:0] PH_HDR_NAME   = 4'd5;
  localparam logic [3:0] PH_HDR_SKIP   = 4'd6;
  localparam logic [3:0] PH_VAL_LEAD   = 4'd7;
  localparam logic [3:0] PH_CONN_VALUE = 4'd8;
  localparam logic [3:0] PH_LEN_DIGITS = 4'd9;
  localparam logic [3:0] PH_BODY       = 4'd10;
  localparam logic [3:0] PH_DONE       = 4'd11;

  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] HK_UNKNOWN = 2'd0;
  localparam logic [1:0] HK_CONN    = 2'd1;
  localparam logic [1:0] HK_CLEN    = 2'd2;

  localparam logic [2:0] UP_START  = 3'd0;
  localparam logic [2:0] UP_HTTP   = 3'd1;
  localparam logic [2:0] UP_HTTPS  = 3'd2;
  localparam logic [2:0] UP_HOST   = 3'd3;
  localparam logic [2:0] UP_ROOT   = 3'd4;
  localparam logic [2:0] UP_PATH   = 3'd5;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        method;
    logic        keep_alive;
    logic [31:0] content_length;
    logic        url_valid;
    logic [7:0]  url_byte;
    logic        url_is_root;
    logic        body_valid;
    logic [7:0]  body_byte;
  } out_t;

  typedef struct packed {
    logic [3:0]        phase;
    logic [3:0]        kidx;
    logic [1:0]        hkind;
    logic              vmatch;
    logic              crp;
    logic [CountW-1:0] rcount;
    logic [31:0]       lenv;
    logic [31:0]       brem;
    logic              meth;
    logic              linger;
    logic [2:0]        ups;
    logic [1:0]        fin;
  } state_t;

  localparam state_t StateReset = '{phase: PH_METHOD, kidx: 4'd0, hkind: HK_UNKNOWN,
      vmatch: 1'b1, crp: 1'b0, rcount: '0, lenv: 32'd0, brem: 32'd0, meth: 1'b0,
      linger: 1'b0, ups: UP_START, fin: ST_PENDING};

  function automatic logic [7:0] kw_get(input logic [3:0] i);
    unique case (i)
      4'd0: kw_get = "g";
      4'd1: kw_get = "e";
      4'd2: kw_get = "t";
      default: kw_get = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_post(input logic [3:0] i);
    unique case (i)
      4'd0: kw_post = "p";
      4'd1: kw_post = "o";
      4'd2: kw_post = "s";
      4'd3: kw_post = "t";
      default: kw_post = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_version(input logic [3:0] i);
    unique case (i)
      4'd0: kw_version = "h";
      4'd1: kw_version = "t";
      4'd2: kw_version = "t";
      4'd3: kw_version = "p";
      4'd4: kw_version = "/";
      4'd5: kw_version = "1";
      4'd6: kw_version = ".";
      4'd7: kw_version = "1";
      default: kw_version = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_https(input logic [3:0] i);
    unique case (i)
      4'd0: kw_https = "h";
      4'd1: kw_https = "t";
      4'd2: kw_https = "t";
      4'd3: kw_https = "p";
      4'd4: kw_https = "s";
      4'd5: kw_https = ":";
      4'd6: kw_https = "/";
      4'd7: kw_https = "/";
      default: kw_https = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_http(input logic [3:0] i);
    unique case (i)
      4'd0: kw_http = "h";
      4'd1: kw_http = "t";
      4'd2: kw_http = "t";
      4'd3: kw_http = "p";
      4'd4: kw_http = ":";
      4'd5: kw_http = "/";
      4'd6: kw_http = "/";
      default: kw_http = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_conn(input logic [3:0] i);
    unique case (i)
      4'd0: kw_conn = "c";
      4'd1: kw_conn = "o";
      4'd2: kw_conn = "n";
      4'd3: kw_conn = "n";
      4'd4: kw_conn = "e";
      4'd5: kw_conn = "c";
      4'd6: kw_conn = "t";
      4'd7: kw_conn = "i";
      4'd8: kw_conn = "o";
      4'd9: kw_conn = "n";
      4'd10: kw_conn = ":";
      default: kw_conn = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_clen(input logic [3:0] i);
    unique case (i)
      4'd0: kw_clen = "c";
      4'd1: kw_clen = "o";
      4'd2: kw_clen = "n";
      4'd3: kw_clen = "t";
      4'd4: kw_clen = "e";
      4'd5: kw_clen = "n";
      4'd6: kw_clen = "t";
      4'd7: kw_clen = "-";
      4'd8: kw_clen = "l";
      4'd9: kw_clen = "e";
      4'd10: kw_clen = "n";
      4'd11: kw_clen = "g";
      4'd12: kw_clen = "t";
      4'd13: kw_clen = "h";
      4'd14: kw_clen = ":";
      default: kw_clen = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_keep(input logic [3:0] i);
    unique case (i)
      4'd0: kw_keep = "k";
      4'd1: kw_keep = "e";
      4'd2: kw_keep = "e";
      4'd3: kw_keep = "p";
      4'd4: kw_keep = "-";
      4'd5: kw_keep = "a";
      4'd6: kw_keep = "l";
      4'd7: kw_keep = "i";
      4'd8: kw_keep = "v";
      4'd9: kw_keep = "e";
      default: kw_keep = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/hrp_chan_if.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser channel
// Valid and ready handshake carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrp_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/hrp_step.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser step
// Next parser state and the result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_step (
  input  var hrp_pkg::state_t st,
  input  var hrp_pkg::in_t    item,
  output var hrp_pkg::state_t st_next,
  output var hrp_pkg::out_t   result
);

  always_comb begin
    hrp_pkg::state_t s;
    hrp_pkg::state_t n;
    logic [7:0]  b;
    logic [7:0]  c;
    logic        blank;
    logic        digit;
    logic [3:0]  k1;
    logic [3:0]  vidx;
    logic [2:0]  ups;
    logic [3:0]  hlen;
    logic [7:0]  hchar;
    logic [35:0] prod;
    logic [31:0] lenadd;
    logic [31:0] bdec;
    logic        urlv;
    logic        bodyv;

    s = item.restart ? hrp_pkg::StateReset : st;
    n = s;
    b = item.data_byte;
    c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    blank = (b == " ") || (b == 8'h09);
    digit = (b >= "0") && (b <= "9");
    k1 = s.kidx + 4'd1;
    urlv = 1'b0;
    bodyv = 1'b0;
    prod = {1'b0, s.lenv, 3'b000} + {3'b000, s.lenv, 1'b0} + {28'd0, b - 8'd48};
    lenadd = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
    bdec = (s.brem != 32'd0) ? s.brem - 32'd1 : 32'd0;
    vidx = (s.phase == hrp_pkg::PH_VER_LEAD) ? 4'd0 : s.kidx;
    ups = (s.phase == hrp_pkg::PH_URL_LEAD) ? hrp_pkg::UP_START : s.ups;
    hlen = (s.hkind == hrp_pkg::HK_CONN) ? 4'd11 : 4'd15;
    hchar = (s.hkind == hrp_pkg::HK_CONN) ? hrp_pkg::kw_conn(s.kidx) : hrp_pkg::kw_clen(s.kidx);

    if (s.fin == hrp_pkg::ST_PENDING) begin
      if (s.rcount >= hrp_pkg::CountW'(hrp_pkg::MaxRequestBytes)) begin
        n.fin = hrp_pkg::ST_OVERFLOW;
      end else begin
        n.rcount = s.rcount + hrp_pkg::CountW'(1);
        if (s.phase == hrp_pkg::PH_BODY) begin
          bodyv = 1'b1;
          n.brem = bdec;
          if (bdec == 32'd0) begin
            n.fin = hrp_pkg::ST_COMPLETE;
            n.phase = hrp_pkg::PH_DONE;
          end
        end else if (s.crp) begin
          n.crp = 1'b0;
          if (b != 8'h0A) begin
            n.fin = hrp_pkg::ST_BAD;
          end else begin
            unique case (s.phase)
              hrp_pkg::PH_VERSION: begin
                if (s.kidx == 4'd8) begin
                  n.phase = hrp_pkg::PH_HDR_NAME;
                  n.kidx = 4'd0;
                  n.hkind = hrp_pkg::HK_UNKNOWN;
                  n.vmatch = 1'b1;
                end else begin
                  n.fin = hrp_pkg::ST_BAD;
                end
              end
              hrp_pkg::PH_HDR_NAME: begin
                if (s.kidx == 4'd0) begin
                  if (s.lenv != 32'd0) begin
                    n.phase = hrp_pkg::PH_BODY;
                    n.brem = s.lenv;
                  end else begin
                    n.fin = hrp_pkg::ST_COMPLETE;
                    n.phase = hrp_pkg::PH_DONE;
                  end
                end else begin
                  n.kidx = 4'd0;
                  n.hkind = hrp_pkg::HK_UNKNOWN;
                  n.vmatch = 1'b1;
                end
              end
              hrp_pkg::PH_CONN_VALUE, hrp_pkg::PH_HDR_SKIP, hrp_pkg::PH_VAL_LEAD,
              hrp_pkg::PH_LEN_DIGITS: begin
                if (s.phase == hrp_pkg::PH_CONN_VALUE && s.vmatch && s.kidx == 4'd10) begin
                  n.linger = 1'b1;
                end
                n.phase = hrp_pkg::PH_HDR_NAME;
                n.kidx = 4'd0;
                n.hkind = hrp_pkg::HK_UNKNOWN;
                n.vmatch = 1'b1;
              end
              default: n.fin = hrp_pkg::ST_BAD;
            endcase
          end
        end else if (b == 8'h0D) begin
          n.crp = 1'b1;
        end else if (b == 8'h0A) begin
          n.fin = hrp_pkg::ST_BAD;
        end else begin
          unique case (s.phase)
            hrp_pkg::PH_METHOD: begin
              if (blank) begin
                if (s.kidx == (s.meth ? 4'd4 : 4'd3)) begin
                  n.phase = hrp_pkg::PH_URL_LEAD;
                  n.kidx = 4'd0;
                end else begin
                  n.fin = hrp_pkg::ST_BAD;
                end
              end else if (s.kidx == 4'd0) begin
                if (c == "g") begin
                  n.meth = 1'b0;
                  n.kidx = 4'd1;
                end else if (c == "p") begin
                  n.meth = 1'b1;
                  n.kidx = 4'd1;
                end else begin
                  n.fin = hrp_pkg::ST_BAD;
                end
              end else if (s.kidx < (s.meth ? 4'd4 : 4'd3) &&
                           c == (s.meth ? hrp_pkg::kw_post(s.kidx) : hrp_pkg::kw_get(s.kidx))) begin
                n.kidx = k1;
              end else begin
                n.fin = hrp_pkg::ST_BAD;
              end
            end
            hrp_pkg::PH_URL_LEAD, hrp_pkg::PH_URL: begin
              if (!(s.phase == hrp_pkg::PH_URL_LEAD && blank)) begin
                n.phase = hrp_pkg::PH_URL;
                n.ups = ups;
                if (blank) begin
                  if (ups == hrp_pkg::UP_ROOT || ups == hrp_pkg::UP_PATH) begin
                    n.phase = hrp_pkg::PH_VER_LEAD;
                  end else begin
                    n.fin = hrp_pkg::ST_BAD;
                  end
                end else begin
                  unique case (ups)
                    hrp_pkg::UP_START: begin
                      if (b == "/") begin
                        urlv = 1'b1;
                        n.ups = hrp_pkg::UP_ROOT;
                      end else if (c == "h") begin
                        n.ups = hrp_pkg::UP_HTTP;
                        n.kidx = 4'd1;
                      end else begin
                        n.fin = hrp_pkg::ST_BAD;
                      end
                    end
                    hrp_pkg::UP_HTTP: begin
                      if (s.kidx == 4'd4 && c == "s") begin
                        n.ups = hrp_pkg::UP_HTTPS;
                        n.kidx = 4'd5;
                      end else if (s.kidx < 4'd7 && c == hrp_pkg::kw_http(s.kidx)) begin
                        n.kidx = k1;
                        if (k1 == 4'd7) n.ups = hrp_pkg::UP_HOST;
                      end else begin
                        n.fin = hrp_pkg::ST_BAD;
                      end
                    end
                    hrp_pkg::UP_HTTPS: begin
                      if (s.kidx < 4'd8 && c == hrp_pkg::kw_https(s.kidx)) begin
                        n.kidx = k1;
                        if (k1 == 4'd8) n.ups = hrp_pkg::UP_HOST;
                      end else begin
                        n.fin = hrp_pkg::ST_BAD;
                      end
                    end
                    hrp_pkg::UP_HOST: begin
                      if (b == "/") begin
                        urlv = 1'b1;
                        n.ups = hrp_pkg::UP_ROOT;
                      end
                    end
                    hrp_pkg::UP_ROOT, hrp_pkg::UP_PATH: begin
                      urlv = 1'b1;
                      n.ups = hrp_pkg::UP_PATH;
                    end
                    default: n.fin = hrp_pkg::ST_BAD;
                  endcase
                end
              end
            end
            hrp_pkg::PH_VER_LEAD, hrp_pkg::PH_VERSION: begin
              if (!(s.phase == hrp_pkg::PH_VER_LEAD && blank)) begin
                n.phase = hrp_pkg::PH_VERSION;
                if (vidx < 4'd8 && c == hrp_pkg::kw_version(vidx)) begin
                  n.kidx = vidx + 4'd1;
                end else begin
                  n.kidx = vidx;
                  n.fin = hrp_pkg::ST_BAD;
                end
              end
            end
            hrp_pkg::PH_HDR_NAME: begin
              if (s.kidx < 4'd3) begin
                if (c == hrp_pkg::kw_conn(s.kidx)) n.kidx = k1;
                else n.phase = hrp_pkg::PH_HDR_SKIP;
              end else if (s.kidx == 4'd3) begin
                if (c == "n") begin
                  n.hkind = hrp_pkg::HK_CONN;
                  n.kidx = 4'd4;
                end else if (c == "t") begin
                  n.hkind = hrp_pkg::HK_CLEN;
                  n.kidx = 4'd4;
                end else begin
                  n.phase = hrp_pkg::PH_HDR_SKIP;
                end
              end else if (s.kidx < hlen && c == hchar) begin
                n.kidx = k1;
                if (k1 == hlen) begin
                  n.phase = hrp_pkg::PH_VAL_LEAD;
                  n.kidx = 4'd0;
                  n.vmatch = 1'b1;
                  if (s.hkind == hrp_pkg::HK_CLEN) n.lenv = 32'd0;
                end
              end else begin
                n.phase = hrp_pkg::PH_HDR_SKIP;
              end
            end
            hrp_pkg::PH_VAL_LEAD: begin
              if (s.hkind == hrp_pkg::HK_CONN) begin
                if (!blank) begin
                  n.phase = hrp_pkg::PH_CONN_VALUE;
                  if (s.kidx < 4'd10 && c == hrp_pkg::kw_keep(s.kidx)) n.kidx = k1;
                  else n.vmatch = 1'b0;
                end
              end else if (!(blank || b == 8'h0B || b == 8'h0C)) begin
                if (b == "+") begin
                  n.phase = hrp_pkg::PH_LEN_DIGITS;
                end else if (digit) begin
                  n.phase = hrp_pkg::PH_LEN_DIGITS;
                  n.lenv = lenadd;
                end else begin
                  n.lenv = 32'd0;
                  n.phase = hrp_pkg::PH_HDR_SKIP;
                end
              end
            end
            hrp_pkg::PH_CONN_VALUE: begin
              if (s.kidx < 4'd10 && c == hrp_pkg::kw_keep(s.kidx)) n.kidx = k1;
              else n.vmatch = 1'b0;
            end
            hrp_pkg::PH_LEN_DIGITS: begin
              if (digit) n.lenv = lenadd;
              else n.phase = hrp_pkg::PH_HDR_SKIP;
            end
            default: ;
          endcase
        end
      end
    end

    st_next = n;
    result.status = n.fin;
    result.method = n.meth;
    result.keep_alive = n.linger;
    result.content_length = n.lenv;
    result.url_valid = urlv;
    result.url_byte = urlv ? b : 8'd0;
    result.url_is_root = (n.ups == hrp_pkg::UP_ROOT) && (n.phase != hrp_pkg::PH_METHOD) &&
                         (n.phase != hrp_pkg::PH_URL_LEAD) && (n.phase != hrp_pkg::PH_URL);
    result.body_valid = bodyv;
    result.body_byte = bodyv ? b : 8'd0;
  end

endmodule

`default_nettype wire

// ===== sv/http_request_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// HTTP request header parser
// Checks an HTTP/1.1 request byte by byte and streams URL and body bytes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   req      in         restart, data_byte
//   res      out        status, method, keep_alive, content_length, url and body
//
// Each byte gives one registered result in the cycle after its transfer.
// A new byte can be taken in every cycle unless req stalls, set by the single state update.
// The result register frees itself when res is taken, so req only stalls
// while a result waits and res.ready is low.
// Reset is synchronous and returns the parser to the method phase.
`default_nettype none

module http_request_header_parser_top (
  input  wire        clk,
  input  wire        rst,
  hrp_chan_if.sink   req,
  hrp_chan_if.source res
);

  hrp_pkg::state_t st;
  hrp_pkg::state_t st_next;
  hrp_pkg::out_t   result;
  logic            take;

  hrp_step u_step (
    .st      (st),
    .item    (req.payload),
    .st_next (st_next),
    .result  (result)
  );

  assign req.ready = !res.valid || res.ready;
  assign take = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hrp_pkg::StateReset;
      res.valid <= 1'b0;
    end else if (take) begin
      st <= st_next;
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.payload <= result;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> res.valid) else $error("transfer gave no result");
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    take && !req.payload.restart && st.fin != hrp_pkg::ST_PENDING |=> st.fin == $past(st.fin))
    else $error("finished status changed without restart");
  a_one_stream: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.payload.url_valid && res.payload.body_valid))
    else $error("URL and body byte in one result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.rcount <= hrp_pkg::CountW'(hrp_pkg::MaxRequestBytes))
    else $error("byte count beyond buffer size");
`endif

endmodule

`default_nettype wire
